[hw/rtl/bf_pkg.sv]
// Shared types and constants for the Blowfish block cipher core.
// No dependencies; every other file in hw/rtl imports this package.
package bf_pkg;

  localparam int unsigned SUBKEY_COUNT = 18;
  localparam int unsigned SBOX_COUNT   = 4;
  localparam int unsigned SBOX_ENTRIES = 256;
  localparam int unsigned ROUNDS       = 16;
  // Request queue depth between front and back; must be a power of two.
  localparam int unsigned QUEUE_DEPTH  = 2;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned LOAD_IDX_W = 10;
  localparam int unsigned KEY_IDX_W = $clog2(SUBKEY_COUNT);
  localparam int unsigned SBOX_IDX_W = $clog2(SBOX_ENTRIES);
  localparam int unsigned SBOX_SEL_W = $clog2(SBOX_COUNT);
  localparam int unsigned ROUND_W   = $clog2(ROUNDS);
  localparam int unsigned QPTR_W    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_ENC  = 2'd0,
    OP_DEC  = 2'd1,
    OP_KEY  = 2'd2,
    OP_SBOX = 2'd3
  } bf_op_e;

  // One queued request. Field a carries the load word for loads and the
  // left half for cipher requests; b carries the right half.
  typedef struct packed {
    bf_op_e                op;
    logic [LOAD_IDX_W-1:0] idx;
    logic [WORD_W-1:0]     a;
    logic [WORD_W-1:0]     b;
  } bf_req_t;

  typedef struct packed {
    logic    valid;
    bf_req_t req;
  } bf_qout_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
  } bf_fstat_t;

  typedef struct packed {
    logic               running;
    logic [ROUND_W-1:0] round;
  } bf_bstat_t;

endpackage

[hw/rtl/bf_front.sv]
// Front end: accepts requests, classifies them and holds them in a short queue.
// Depends on bf_pkg.
module bf_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [1:0]                    cmd_i,
  input  logic [bf_pkg::LOAD_IDX_W-1:0] load_index_i,
  input  logic [bf_pkg::WORD_W-1:0]     load_word_i,
  input  logic [bf_pkg::WORD_W-1:0]     left_in_i,
  input  logic [bf_pkg::WORD_W-1:0]     right_in_i,
  output logic                          busy_o,
  input  logic                          pop_i,
  output bf_pkg::bf_qout_t              q_o,
  output bf_pkg::bf_fstat_t             stat_o
);
  import bf_pkg::*;

  bf_req_t           fifo_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  bf_req_t           req;
  logic              keep, push, pop;

  always_comb begin
    req.op  = bf_op_e'(cmd_i);
    req.idx = load_index_i;
    req.a   = (req.op == OP_KEY || req.op == OP_SBOX) ? load_word_i : left_in_i;
    req.b   = right_in_i;
    // Subkey loads past the last subkey change nothing, so they are dropped here.
    keep = !(req.op == OP_KEY && load_index_i >= LOAD_IDX_W'(SUBKEY_COUNT));
  end

  assign busy_o = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign push   = start_i && !busy_o && keep;
  assign pop    = pop_i && (cnt_q != '0);

  always_comb begin
    wptr_d = push ? wptr_q + QPTR_W'(1) : wptr_q;
    rptr_d = pop ? rptr_q + QPTR_W'(1) : rptr_q;
    cnt_d  = cnt_q + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= req;
    end
  end

  assign q_o.valid    = (cnt_q != '0);
  assign q_o.req      = fifo_q[rptr_q];
  assign stat_o.count = cnt_q;

endmodule

[hw/rtl/bf_back.sv]
// Back end: key stores, S-box memories and the round datapath, one round a cycle.
// Depends on bf_pkg.
module bf_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bf_pkg::bf_qout_t          q_i,
  output logic                      pop_o,
  output logic                      done_o,
  output logic [bf_pkg::WORD_W-1:0] left_out_o,
  output logic [bf_pkg::WORD_W-1:0] right_out_o,
  output bf_pkg::bf_bstat_t         stat_o
);
  import bf_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_ROUND
  } state_e;

  state_e              state_q;
  logic [ROUND_W-1:0]  round_q;
  logic                dec_q, done_q;
  logic [WORD_W-1:0]   xl_q, r_q, lout_q, rout_q;
  logic [WORD_W-1:0]   subkey_q [SUBKEY_COUNT];

  logic [WORD_W-1:0]     sdata [SBOX_COUNT];
  logic [SBOX_IDX_W-1:0] raddr [SBOX_COUNT];
  logic [SBOX_COUNT-1:0] sbox_we;

  logic                 idle, dec_sel, take;
  logic [KEY_IDX_W-1:0] step, kidx;
  logic [WORD_W-1:0]    f_val, new_r, base, xl_d, wkey_l;

  assign idle  = (state_q == ST_IDLE);
  assign take  = idle && q_i.valid;
  assign pop_o = take;

  always_comb begin
    // In idle the first subkey is applied to the incoming left half; in a
    // round the subkey of the following round is applied to the new left half.
    step    = idle ? '0 : KEY_IDX_W'(round_q) + KEY_IDX_W'(1);
    dec_sel = idle ? (q_i.req.op == OP_DEC) : dec_q;
    kidx    = dec_sel ? KEY_IDX_W'(SUBKEY_COUNT - 1) - step : step;
    f_val   = ((sdata[0] + sdata[1]) ^ sdata[2]) + sdata[3];
    new_r   = r_q ^ f_val;
    base    = idle ? q_i.req.a : new_r;
    xl_d    = base ^ subkey_q[kidx];
    wkey_l  = dec_q ? subkey_q[0] : subkey_q[SUBKEY_COUNT-1];
  end

  for (genvar g = 0; g < SBOX_COUNT; g++) begin : g_box
    logic [WORD_W-1:0] mem_q [SBOX_ENTRIES];
    logic [WORD_W-1:0] rdata_q;

    assign raddr[g]   = xl_d[(SBOX_COUNT-1-g)*SBOX_IDX_W +: SBOX_IDX_W];
    assign sbox_we[g] = take && (q_i.req.op == OP_SBOX) &&
                        (q_i.req.idx[LOAD_IDX_W-1:SBOX_IDX_W] == SBOX_SEL_W'(g));
    assign sdata[g]   = rdata_q;

    always_ff @(posedge clk_i) begin
      if (sbox_we[g]) begin
        mem_q[q_i.req.idx[SBOX_IDX_W-1:0]] <= q_i.req.a;
      end
      rdata_q <= mem_q[raddr[g]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && q_i.req.op == OP_KEY) begin
      subkey_q[q_i.req.idx[KEY_IDX_W-1:0]] <= q_i.req.a;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      round_q <= '0;
      dec_q   <= 1'b0;
      done_q  <= 1'b0;
      xl_q    <= '0;
      r_q     <= '0;
      lout_q  <= '0;
      rout_q  <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (take && (q_i.req.op == OP_ENC || q_i.req.op == OP_DEC)) begin
            state_q <= ST_ROUND;
            round_q <= '0;
            dec_q   <= (q_i.req.op == OP_DEC);
            xl_q    <= xl_d;
            r_q     <= q_i.req.b;
          end
        end
        ST_ROUND: begin
          if (round_q == ROUND_W'(ROUNDS - 1)) begin
            // Final swap folded in: the right half takes the whitening
            // subkey through the same path as a next-round key.
            lout_q  <= xl_q ^ wkey_l;
            rout_q  <= xl_d;
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            xl_q    <= xl_d;
            r_q     <= xl_q;
            round_q <= round_q + ROUND_W'(1);
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign done_o         = done_q;
  assign left_out_o     = lout_q;
  assign right_out_o    = rout_q;
  assign stat_o.running = !idle;
  assign stat_o.round   = round_q;

endmodule

[hw/rtl/blowfish_block_cipher_top.sv]
// Blowfish block cipher core, top level. Depends on bf_pkg, bf_front, bf_back.
// A block is issued and then runs its sixteen rounds before the back end takes
// another request, the round rate being set by the S-box read feeding the next
// round's addresses; loads are taken only while the back end is idle.
// The result strobe lasts one cycle; the receiver cannot stall.
// Reset clears the queue and control; subkeys and S-boxes are undefined until loaded.
module blowfish_block_cipher_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [1:0]                    cmd_i,
  input  logic [bf_pkg::LOAD_IDX_W-1:0] load_index_i,
  input  logic [bf_pkg::WORD_W-1:0]     load_word_i,
  input  logic [bf_pkg::WORD_W-1:0]     left_in_i,
  input  logic [bf_pkg::WORD_W-1:0]     right_in_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [bf_pkg::WORD_W-1:0]     left_out_o,
  output logic [bf_pkg::WORD_W-1:0]     right_out_o
);
  import bf_pkg::*;

  // A request is taken whenever the queue has room, so loads and new blocks
  // can be queued while the back end is still working through a block.
  bf_qout_t  q;
  bf_fstat_t fstat;
  bf_bstat_t bstat;
  logic      pop;

  bf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .cmd_i        (cmd_i),
    .load_index_i (load_index_i),
    .load_word_i  (load_word_i),
    .left_in_i    (left_in_i),
    .right_in_i   (right_in_i),
    .busy_o       (busy_o),
    .pop_i        (pop),
    .q_o          (q),
    .stat_o       (fstat)
  );

  // The back end takes one request from the queue whenever it is idle, and
  // carries out the sixteen rounds with the S-box reads pipelined one ahead.
  bf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_i         (q),
    .pop_o       (pop),
    .done_o      (done_o),
    .left_out_o  (left_out_o),
    .right_out_o (right_out_o),
    .stat_o      (bstat)
  );

  // A result strobe is never followed directly by another.
  a_done_spaced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobes too close together");

  // The queue never holds more than its depth.
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fstat.count <= QCNT_W'(QUEUE_DEPTH))
    else $error("request queue overflow");

  // Every block starts at the first round.
  a_round_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(bstat.running) |-> (bstat.round == '0))
    else $error("block started at a nonzero round");

  // A result follows only the last round.
  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_o) |-> $past(bstat.running) && ($past(bstat.round) == ROUND_W'(ROUNDS - 1)))
    else $error("result without a finished block");

endmodule

[tb/blowfish_block_cipher_top_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for blowfish_block_cipher_top: loads key material, then runs
// directed and random encrypt, decrypt and reload requests against an in-bench predictor.
// Depends on bf_pkg and the RTL of the core; reads no files.
module blowfish_block_cipher_top_test;
  import bf_pkg::*;

  localparam int unsigned CLK_HALF    = 4;
  localparam int unsigned RANDOM_REQS = 700;
  localparam int unsigned TAIL_CYCLES = 40;
  // The slowest legal run is about 1900 requests, each with the longest gap plus
  // a full block time; the limit leaves plenty of margin on top.
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SBOX_WORDS  = SBOX_COUNT * SBOX_ENTRIES;

  // One request as the driver presents it on the input ports.
  typedef struct {
    bf_op_e                op;
    logic [LOAD_IDX_W-1:0] idx;
    logic [WORD_W-1:0]     word;
    logic [WORD_W-1:0]     left;
    logic [WORD_W-1:0]     right;
  } cipher_req_t;

  // One 64-bit block, as two halves.
  typedef struct packed {
    logic [WORD_W-1:0] left;
    logic [WORD_W-1:0] right;
  } block_t;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  start_i      = 1'b0;
  logic [1:0]            cmd_i        = OP_ENC;
  logic [LOAD_IDX_W-1:0] load_index_i = '0;
  logic [WORD_W-1:0]     load_word_i  = '0;
  logic [WORD_W-1:0]     left_in_i    = '0;
  logic [WORD_W-1:0]     right_in_i   = '0;
  logic                  busy_o;
  logic                  done_o;
  logic [WORD_W-1:0]     left_out_o;
  logic [WORD_W-1:0]     right_out_o;

  // Requests waiting to be driven, and blocks that the core still owes us.
  cipher_req_t pending_reqs[$];
  block_t      blocks_due[$];

  // The predictor's own copy of the key material.
  logic [WORD_W-1:0] key_words[SUBKEY_COUNT];
  logic [WORD_W-1:0] sbox_words[SBOX_WORDS];

  int unsigned issued_cnt = 0;
  int unsigned taken_cnt  = 0;
  int unsigned err_cnt    = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned idle_left  = 0;
  int unsigned steady_left = 0;

  blowfish_block_cipher_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .cmd_i        (cmd_i),
    .load_index_i (load_index_i),
    .load_word_i  (load_word_i),
    .left_in_i    (left_in_i),
    .right_in_i   (right_in_i),
    .busy_o       (busy_o),
    .done_o       (done_o),
    .left_out_o   (left_out_o),
    .right_out_o  (right_out_o)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
  end

  // The Blowfish F function: four S-box lookups, one per byte of the argument,
  // combined as ((S0 + S1) ^ S2) + S3 modulo 2^32.
  function automatic logic [WORD_W-1:0] sbox_mix(logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] s0, s1, s2, s3;
    s0 = sbox_words[0 * SBOX_ENTRIES + x[31:24]];
    s1 = sbox_words[1 * SBOX_ENTRIES + x[23:16]];
    s2 = sbox_words[2 * SBOX_ENTRIES + x[15:8]];
    s3 = sbox_words[3 * SBOX_ENTRIES + x[7:0]];
    return ((s0 + s1) ^ s2) + s3;
  endfunction

  // Sixteen Feistel rounds, an undo of the last swap, then output whitening.
  // Decryption walks the subkeys from the top down and whitens with the first two.
  function automatic block_t feistel_block(bit decrypt, logic [WORD_W-1:0] l,
                                           logic [WORD_W-1:0] r);
    logic [WORD_W-1:0] swap;
    int unsigned       k;
    block_t            res;
    for (int i = 0; i < ROUNDS; i++) begin
      k    = decrypt ? SUBKEY_COUNT - 1 - i : i;
      l    = l ^ key_words[k];
      r    = r ^ sbox_mix(l);
      swap = l;
      l    = r;
      r    = swap;
    end
    if (decrypt) begin
      res.left  = r ^ key_words[0];
      res.right = l ^ key_words[1];
    end else begin
      res.left  = r ^ key_words[ROUNDS + 1];
      res.right = l ^ key_words[ROUNDS];
    end
    return res;
  endfunction

  // Data words lean toward the all-zero and all-one patterns now and then.
  function automatic logic [WORD_W-1:0] data_word();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Gap before the next request: mostly none or short, a few long, and now and
  // then a stretch of back-to-back requests.
  function automatic int unsigned draw_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (steady_left > 0) begin
      steady_left--;
      return 0;
    end
    if (pick < 3) begin
      steady_left = $urandom_range(10, 40);
      return 0;
    end
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 20);
    return $urandom_range(21, 60);
  endfunction

  task automatic add_request(bf_op_e op, logic [LOAD_IDX_W-1:0] idx,
                             logic [WORD_W-1:0] word, logic [WORD_W-1:0] left,
                             logic [WORD_W-1:0] right);
    cipher_req_t req;
    req.op    = op;
    req.idx   = idx;
    req.word  = word;
    req.left  = left;
    req.right = right;
    pending_reqs.push_back(req);
  endtask

  // Cipher request with random bits in the fields that it ignores.
  task automatic add_block(bf_op_e op, logic [WORD_W-1:0] left, logic [WORD_W-1:0] right);
    add_request(op, LOAD_IDX_W'($urandom_range(0, 1023)), data_word(), left, right);
  endtask

  // Load request with random bits in the block halves, which loads ignore.
  task automatic add_load(bf_op_e op, logic [LOAD_IDX_W-1:0] idx, logic [WORD_W-1:0] word);
    add_request(op, idx, word, data_word(), data_word());
  endtask

  task automatic report_mismatch(string what, logic [WORD_W-1:0] want,
                                 logic [WORD_W-1:0] got);
    err_cnt++;
    $display("[%0t] %s: expected %08h, got %08h", $time, what, want, got);
  endtask

  // Driver: changes inputs on the falling edge. A presented request is held until
  // the rising edge that accepts it has bumped taken_cnt; only then may a gap or
  // the next request follow. Each branch makes at most one assignment to start_i.
  always @(negedge clk_i) begin
    cipher_req_t req;
    if (rst_ni) begin
      if (start_i && taken_cnt != issued_cnt) begin
        // Still waiting for the core to take the current request.
      end else if (idle_left > 0) begin
        idle_left--;
        start_i <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        req          = pending_reqs.pop_front();
        cmd_i        <= req.op;
        load_index_i <= req.idx;
        load_word_i  <= req.word;
        left_in_i    <= req.left;
        right_in_i   <= req.right;
        start_i      <= 1'b1;
        issued_cnt++;
        idle_left = draw_gap();
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor and predictor on the rising edge. The result strobe is checked first,
  // against the oldest block still owed; then an accepted request updates the key
  // material or queues the block it will produce. The core is in order, so loads
  // accepted after a cipher request never affect that request's result.
  always @(posedge clk_i) begin
    block_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (blocks_due.size() == 0) begin
          report_mismatch("result with no request outstanding", '0, left_out_o);
        end else begin
          want = blocks_due.pop_front();
          if (left_out_o !== want.left) report_mismatch("left_out", want.left, left_out_o);
          if (right_out_o !== want.right) report_mismatch("right_out", want.right, right_out_o);
        end
      end
      if (start_i && !busy_o) begin
        taken_cnt++;
        case (bf_op_e'(cmd_i))
          OP_KEY: begin
            // Subkey indexes past the last subkey are dropped by the core.
            if (load_index_i < LOAD_IDX_W'(SUBKEY_COUNT)) begin
              key_words[load_index_i[KEY_IDX_W-1:0]] = load_word_i;
            end
          end
          OP_SBOX: begin
            sbox_words[load_index_i] = load_word_i;
          end
          OP_ENC: begin
            blocks_due.push_back(feistel_block(1'b0, left_in_i, right_in_i));
          end
          OP_DEC: begin
            blocks_due.push_back(feistel_block(1'b1, left_in_i, right_in_i));
          end
          default: begin
          end
        endcase
      end
    end
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int unsigned made;
    int unsigned pick;

    // Every subkey and S-box entry is loaded before the first cipher request, so
    // no request ever reads an entry that was never written.
    for (int i = 0; i < SUBKEY_COUNT; i++) add_load(OP_KEY, LOAD_IDX_W'(i), data_word());
    for (int i = 0; i < SBOX_WORDS; i++) add_load(OP_SBOX, LOAD_IDX_W'(i), data_word());

    // Directed part: block extremes both ways, ignored subkey indexes, reloads at
    // the edges of the subkey array and at an edge of each S-box, and unused fields
    // at their extremes.
    add_request(OP_ENC, 10'h3ff, '1, '0, '0);
    add_request(OP_ENC, '0, '0, '1, '1);
    add_request(OP_DEC, 10'h3ff, '1, '0, '0);
    add_request(OP_DEC, '0, '0, '1, '1);
    add_block(OP_ENC, 32'h0123_4567, 32'h89ab_cdef);
    add_request(OP_KEY, LOAD_IDX_W'(SUBKEY_COUNT), '1, '1, '1);
    add_request(OP_KEY, 10'h3ff, '0, '0, '0);
    add_block(OP_ENC, $urandom, $urandom);
    add_load(OP_KEY, '0, '0);
    add_load(OP_KEY, LOAD_IDX_W'(SUBKEY_COUNT - 1), '1);
    add_block(OP_ENC, $urandom, $urandom);
    add_block(OP_DEC, $urandom, $urandom);
    add_load(OP_SBOX, '0, '1);
    add_load(OP_SBOX, LOAD_IDX_W'(SBOX_WORDS - 1), '0);
    add_load(OP_SBOX, LOAD_IDX_W'(SBOX_ENTRIES), $urandom);
    add_load(OP_SBOX, LOAD_IDX_W'(3 * SBOX_ENTRIES - 1), $urandom);
    add_block(OP_ENC, '1, '0);
    add_block(OP_DEC, '0, '1);
    for (int i = 0; i < 4; i++) add_block(bf_op_e'(i % 2), $urandom, $urandom);

    // Random part: mostly cipher requests, with reloads of random entries mixed in
    // so that the key material keeps changing under the traffic. Subkey loads that
    // the core drops do not count toward the total.
    made = 0;
    while (made < RANDOM_REQS) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        add_block(pick[0] ? OP_DEC : OP_ENC, data_word(), data_word());
        made++;
      end else if (pick < 80) begin
        add_load(OP_SBOX, LOAD_IDX_W'($urandom_range(0, SBOX_WORDS - 1)), data_word());
        made++;
      end else if (pick < 90) begin
        add_load(OP_KEY, LOAD_IDX_W'($urandom_range(0, SUBKEY_COUNT - 1)), data_word());
        made++;
      end else begin
        add_load(OP_KEY, LOAD_IDX_W'($urandom_range(SUBKEY_COUNT, 1023)), data_word());
      end
    end

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Drain: every request taken and every owed block seen, then a wait of
    // TAIL_CYCLES in case a stray result follows.
    while (pending_reqs.size() > 0 || taken_cnt != issued_cnt || blocks_due.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
